@@ hdl/dhcpop_pkg.sv @@
package dhcpop_pkg;

	// Region and relay sizes
	localparam int MAX_REGION_BYTES = 2048;
	localparam int REMOTE_ID_BYTES  = 8;
	localparam int POS_W            = $clog2(MAX_REGION_BYTES + 1);

	// Option and sub-option codes
	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_REQ_ADDR = 8'd50;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_RELAY    = 8'd82;
	localparam logic [7:0] OPT_END      = 8'd255;
	localparam logic [7:0] SUB_CIRCUIT  = 8'd1;
	localparam logic [7:0] SUB_REMOTE   = 8'd2;
	localparam logic [7:0] CIRCUIT_LEN  = 8'd4;
	localparam logic [7:0] REMOTE_LEN   = 8'(REMOTE_ID_BYTES);
	localparam logic [7:0] RELAY_LEN    = 8'(8 + REMOTE_ID_BYTES);

	// Magic cookie, first byte at index 0
	localparam logic [7:0] COOKIE [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

	typedef enum logic [2:0] {
		PH_COOKIE,
		PH_CODE,
		PH_LEN,
		PH_VALUE,
		PH_DONE
	} walk_phase_t;

	typedef enum logic [1:0] {
		SP_IDLE,
		SP_CODE,
		SP_LEN,
		SP_VAL
	} sub_phase_t;

	typedef struct packed {
		logic [7:0] option_byte;
		logic       last_byte;
	} opt_in_t;

	typedef struct packed {
		logic        region_ok;
		logic [7:0]  message_type;
		logic        message_type_found;
		logic [31:0] requested_address;
		logic        requested_address_found;
		logic [31:0] circuit_index;
		logic        circuit_index_found;
		logic [63:0] remote_ident;
		logic        remote_ident_found;
		logic        end_option_seen;
	} opt_out_t;

	// Walker to relay decoder control
	typedef struct packed {
		logic       start;
		logic       start_ok;
		logic       byte_en;
		logic       clear;
		logic [7:0] data;
	} relay_ctl_t;

	// Relay sub-option captures after the current byte
	typedef struct packed {
		logic [31:0] circuit;
		logic        circuit_found;
		logic [63:0] remote;
		logic        remote_found;
	} relay_cap_t;

endpackage

@@ hdl/dhcp_option_parser_unit.sv @@
// DHCP options region parser, one request (one option byte) per cycle while byte_stall is low.
// The request carrying the last byte is held in the input register, then its
// result is loaded into the result register once that register is free.
// Throughput: one byte per cycle; bytes keep flowing while a result waits,
// only a further last byte stalls until the result register is taken.
// Reset (arst_n low) clears all packet state and empties both registers.
module dhcp_option_parser_unit
	import dhcpop_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  opt_in_t  byte_data,
	output logic     result_valid,
	input  logic     result_stall,
	output opt_out_t result
);

	opt_in_t  item_s1;
	logic     valid_s1;
	logic     advance;
	opt_out_t walk_res;
	opt_out_t res_q;
	logic     res_valid_q;

	// Process the held request unless its result has nowhere to go
	assign advance    = valid_s1 && (!item_s1.last_byte || !res_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	// Hold the input request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	dhcpop_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (walk_res)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			res_q <= walk_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ hdl/dhcpop_relay.sv @@
module dhcpop_relay
	import dhcpop_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  relay_ctl_t ctl,
	output relay_cap_t cap
);

	sub_phase_t  phase_q, n_phase;
	logic        is_circ_q, n_is_circ;
	logic [7:0]  len_q, n_len;
	logic [1:0]  count_q, n_count;
	logic [63:0] gather_q, n_gather;
	relay_cap_t  cap_q, n_cap;
	logic [2:0]  lane;
	logic [7:0]  need;

	assign lane = 3'(REMOTE_LEN - len_q);
	assign need = is_circ_q ? CIRCUIT_LEN : REMOTE_LEN;

	// Advance the sub-option walk by one byte
	always_comb begin
		n_phase   = phase_q;
		n_is_circ = is_circ_q;
		n_len     = len_q;
		n_count   = count_q;
		n_gather  = gather_q;
		n_cap     = cap_q;
		if (ctl.start) begin
			n_count = 2'd0;
			n_phase = ctl.start_ok ? SP_CODE : SP_IDLE;
		end else if (ctl.byte_en) begin
			unique case (phase_q)
				SP_IDLE: begin
				end
				SP_CODE: begin
					if (ctl.data == SUB_CIRCUIT) begin
						n_is_circ = 1'b1;
						n_phase   = SP_LEN;
					end else if (ctl.data == SUB_REMOTE) begin
						n_is_circ = 1'b0;
						n_phase   = SP_LEN;
					end else begin
						n_phase = SP_IDLE;
					end
				end
				SP_LEN: begin
					if (ctl.data != need) begin
						n_phase = SP_IDLE;
					end else begin
						n_len    = ctl.data;
						n_gather = '0;
						n_phase  = SP_VAL;
					end
				end
				SP_VAL: begin
					if (is_circ_q) begin
						n_gather = {32'd0, gather_q[23:0], ctl.data};
					end else begin
						n_gather[{lane, 3'b000} +: 8] = gather_q[{lane, 3'b000} +: 8] | ctl.data;
					end
					n_len = len_q - 8'd1;
					if (n_len == 8'd0) begin
						if (is_circ_q) begin
							n_cap.circuit       = n_gather[31:0];
							n_cap.circuit_found = 1'b1;
						end else begin
							n_cap.remote       = n_gather;
							n_cap.remote_found = 1'b1;
						end
						n_count = count_q + 2'd1;
						n_phase = (count_q >= 2'd1) ? SP_IDLE : SP_CODE;
					end
				end
				default: n_phase = SP_IDLE;
			endcase
		end
	end

	// Show captures including this byte
	assign cap = n_cap;

	// Hold state; drop it at the end of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= SP_IDLE;
			is_circ_q <= 1'b0;
			len_q     <= '0;
			count_q   <= '0;
			gather_q  <= '0;
			cap_q     <= '0;
		end else if (ctl.clear) begin
			phase_q   <= SP_IDLE;
			is_circ_q <= 1'b0;
			len_q     <= '0;
			count_q   <= '0;
			gather_q  <= '0;
			cap_q     <= '0;
		end else begin
			phase_q   <= n_phase;
			is_circ_q <= n_is_circ;
			len_q     <= n_len;
			count_q   <= n_count;
			gather_q  <= n_gather;
			cap_q     <= n_cap;
		end
	end

endmodule

@@ hdl/dhcpop_walk.sv @@
module dhcpop_walk
	import dhcpop_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  opt_in_t  item,
	output opt_out_t result
);

	walk_phase_t      phase_q, n_phase;
	logic [POS_W-1:0] pos_q, n_pos;
	logic [7:0]       code_q, n_code;
	logic [7:0]       len_q, n_len;
	logic [7:0]       vidx_q, n_vidx;
	logic [31:0]      gather_q, n_gather;
	logic             cookie_good_q, n_cookie_good;
	logic [7:0]       type_q, n_type;
	logic             type_found_q, n_type_found;
	logic [31:0]      addr_q, n_addr;
	logic             addr_found_q, n_addr_found;
	logic             end_seen_q, n_end_seen;
	logic             active;
	logic             value_done;
	logic [7:0]       b;
	relay_ctl_t       rctl;
	relay_cap_t       rcap;
	logic             ok;

	assign b          = item.option_byte;
	assign active     = en && (pos_q < POS_W'(MAX_REGION_BYTES));
	assign value_done = ({1'b0, vidx_q} + 9'd1) >= {1'b0, len_q};

	// Feed the relay decoder
	always_comb begin
		rctl.start    = active && (phase_q == PH_LEN) && (code_q == OPT_RELAY);
		rctl.start_ok = (b == RELAY_LEN);
		rctl.byte_en  = active && (phase_q == PH_VALUE) && (code_q == OPT_RELAY);
		rctl.clear    = en && item.last_byte;
		rctl.data     = b;
	end

	dhcpop_relay u_relay (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.cap    (rcap)
	);

	// Advance the option walk by one byte
	always_comb begin
		n_phase       = phase_q;
		n_pos         = pos_q;
		n_code        = code_q;
		n_len         = len_q;
		n_vidx        = vidx_q;
		n_gather      = gather_q;
		n_cookie_good = cookie_good_q;
		n_type        = type_q;
		n_type_found  = type_found_q;
		n_addr        = addr_q;
		n_addr_found  = addr_found_q;
		n_end_seen    = end_seen_q;
		if (active) begin
			n_pos = pos_q + POS_W'(1);
			unique case (phase_q)
				PH_COOKIE: begin
					if (b != COOKIE[pos_q[1:0]]) begin
						n_cookie_good = 1'b0;
						n_phase       = PH_DONE;
					end else if (pos_q >= POS_W'(3)) begin
						n_phase = PH_CODE;
					end
				end
				PH_CODE: begin
					if (b == OPT_END) begin
						n_end_seen = 1'b1;
						n_phase    = PH_DONE;
					end else if (b != OPT_PAD) begin
						n_code  = b;
						n_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					n_len    = b;
					n_vidx   = '0;
					n_gather = '0;
					// zero length captures nothing
					n_phase  = (b == 8'd0) ? PH_CODE : PH_VALUE;
				end
				PH_VALUE: begin
					if (code_q == OPT_MSG_TYPE) begin
						if (vidx_q == 8'd0) begin
							n_gather = {24'd0, b};
						end
					end else if (code_q == OPT_REQ_ADDR) begin
						if (vidx_q < 8'd4) begin
							n_gather = {gather_q[23:0], b};
						end
					end
					if (value_done) begin
						if (code_q == OPT_MSG_TYPE) begin
							n_type       = n_gather[7:0];
							n_type_found = 1'b1;
						end else if (code_q == OPT_REQ_ADDR && len_q >= 8'd4) begin
							n_addr       = n_gather;
							n_addr_found = 1'b1;
						end
						n_phase = PH_CODE;
					end else begin
						n_vidx = vidx_q + 8'd1;
					end
				end
				PH_DONE: begin
				end
				default: n_phase = PH_DONE;
			endcase
		end
	end

	// Form the packet result from the updated state
	always_comb begin
		ok = n_cookie_good && (n_phase != PH_COOKIE);
		result.region_ok               = ok;
		result.message_type            = ok ? n_type : 8'd0;
		result.message_type_found      = ok && n_type_found;
		result.requested_address       = ok ? n_addr : 32'd0;
		result.requested_address_found = ok && n_addr_found;
		result.circuit_index           = ok ? rcap.circuit : 32'd0;
		result.circuit_index_found     = ok && rcap.circuit_found;
		result.remote_ident            = ok ? rcap.remote : 64'd0;
		result.remote_ident_found      = ok && rcap.remote_found;
		result.end_option_seen         = ok && n_end_seen;
	end

	// Hold state; drop it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_COOKIE;
			pos_q         <= '0;
			code_q        <= '0;
			len_q         <= '0;
			vidx_q        <= '0;
			gather_q      <= '0;
			cookie_good_q <= 1'b1;
			type_q        <= '0;
			type_found_q  <= 1'b0;
			addr_q        <= '0;
			addr_found_q  <= 1'b0;
			end_seen_q    <= 1'b0;
		end else if (en) begin
			if (item.last_byte) begin
				phase_q       <= PH_COOKIE;
				pos_q         <= '0;
				code_q        <= '0;
				len_q         <= '0;
				vidx_q        <= '0;
				gather_q      <= '0;
				cookie_good_q <= 1'b1;
				type_q        <= '0;
				type_found_q  <= 1'b0;
				addr_q        <= '0;
				addr_found_q  <= 1'b0;
				end_seen_q    <= 1'b0;
			end else begin
				phase_q       <= n_phase;
				pos_q         <= n_pos;
				code_q        <= n_code;
				len_q         <= n_len;
				vidx_q        <= n_vidx;
				gather_q      <= n_gather;
				cookie_good_q <= n_cookie_good;
				type_q        <= n_type;
				type_found_q  <= n_type_found;
				addr_q        <= n_addr;
				addr_found_q  <= n_addr_found;
				end_seen_q    <= n_end_seen;
			end
		end
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import dhcpop_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// One staged request, with a flag to hold it until all summaries are back
	typedef struct packed {
		logic    drain;
		opt_in_t req;
	} staged_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_stall;
	opt_in_t  byte_data = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	opt_out_t result;

	dhcp_option_parser_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	staged_t    byte_queue[$];
	opt_out_t   expected_summaries[$];
	logic [7:0] pkt[$];
	logic [7:0] relay_body[$];
	int         staged_count;
	int         fail_count;
	int         cycle_count;

	// Parser shadow state
	walk_phase_t walk_ph;
	int          walk_pos;
	logic [7:0]  cur_code;
	int          cur_len;
	int          val_idx;
	logic [63:0] gather;
	sub_phase_t  sub_ph;
	logic [7:0]  sub_cd;
	int          sub_left;
	int          sub_cnt;
	logic        sub_bad;
	logic        cookie_ok;
	opt_out_t    walk_caps;

	function automatic void clear_packet_walk();
		walk_ph = PH_COOKIE;
		walk_pos = 0;
		cur_code = '0;
		cur_len = 0;
		val_idx = 0;
		gather = '0;
		sub_ph = SP_IDLE;
		sub_cd = '0;
		sub_left = 0;
		sub_cnt = 0;
		sub_bad = 1'b0;
		cookie_ok = 1'b1;
		walk_caps = '0;
	endfunction

	initial clear_packet_walk();

	// Decode one byte of the relay option body
	function automatic void relay_sub_byte(logic [7:0] b);
		int k;
		if (sub_bad || sub_ph == SP_IDLE)
			return;
		case (sub_ph)
			SP_CODE: begin
				sub_cd = b;
				if (b != SUB_CIRCUIT && b != SUB_REMOTE) begin
					sub_bad = 1'b1;
					sub_ph = SP_IDLE;
				end else
					sub_ph = SP_LEN;
			end
			SP_LEN: begin
				if (b != ((sub_cd == SUB_CIRCUIT) ? CIRCUIT_LEN : REMOTE_LEN)) begin
					sub_bad = 1'b1;
					sub_ph = SP_IDLE;
				end else begin
					sub_left = b;
					gather = '0;
					sub_ph = SP_VAL;
				end
			end
			default: begin
				if (sub_cd == SUB_CIRCUIT)
					gather = {32'd0, gather[23:0], b};
				else begin
					k = (REMOTE_ID_BYTES - sub_left) & 7;
					gather = gather | ({56'd0, b} << (8 * k));
				end
				sub_left--;
				if (sub_left == 0) begin
					if (sub_cd == SUB_CIRCUIT) begin
						walk_caps.circuit_index = gather[31:0];
						walk_caps.circuit_index_found = 1'b1;
					end else begin
						walk_caps.remote_ident = gather;
						walk_caps.remote_ident_found = 1'b1;
					end
					sub_cnt++;
					sub_ph = (sub_cnt >= 2) ? SP_IDLE : SP_CODE;
				end
			end
		endcase
	endfunction

	function automatic void close_option();
		if (cur_code == OPT_MSG_TYPE && cur_len >= 1) begin
			walk_caps.message_type = gather[7:0];
			walk_caps.message_type_found = 1'b1;
		end else if (cur_code == OPT_REQ_ADDR && cur_len >= 4) begin
			walk_caps.requested_address = gather[31:0];
			walk_caps.requested_address_found = 1'b1;
		end
		walk_ph = PH_CODE;
	endfunction

	// Advance the walk by one request; return 1 with the packet summary on the last byte
	function automatic bit parse_option_byte(opt_in_t req, output opt_out_t summary);
		logic [7:0] b;
		b = req.option_byte;
		if (walk_pos < MAX_REGION_BYTES) begin
			case (walk_ph)
				PH_COOKIE: begin
					if (b != COOKIE[walk_pos & 3]) begin
						cookie_ok = 1'b0;
						walk_ph = PH_DONE;
					end else if (walk_pos >= 3)
						walk_ph = PH_CODE;
				end
				PH_CODE: begin
					if (b == OPT_END) begin
						walk_caps.end_option_seen = 1'b1;
						walk_ph = PH_DONE;
					end else if (b != OPT_PAD) begin
						cur_code = b;
						walk_ph = PH_LEN;
					end
				end
				PH_LEN: begin
					cur_len = b;
					val_idx = 0;
					gather = '0;
					if (cur_code == OPT_RELAY) begin
						sub_cnt = 0;
						sub_bad = (b != RELAY_LEN);
						sub_ph = sub_bad ? SP_IDLE : SP_CODE;
					end
					if (b == 8'd0)
						close_option();
					else
						walk_ph = PH_VALUE;
				end
				PH_VALUE: begin
					if (cur_code == OPT_MSG_TYPE) begin
						if (val_idx == 0)
							gather = {56'd0, b};
					end else if (cur_code == OPT_REQ_ADDR) begin
						if (val_idx < 4)
							gather = {32'd0, gather[23:0], b};
					end else if (cur_code == OPT_RELAY)
						relay_sub_byte(b);
					if (val_idx + 1 >= cur_len)
						close_option();
					else
						val_idx++;
				end
				default: ;
			endcase
			walk_pos++;
		end
		summary = '0;
		if (!req.last_byte)
			return 1'b0;
		if (cookie_ok && walk_ph != PH_COOKIE) begin
			summary = walk_caps;
			summary.region_ok = 1'b1;
		end
		clear_packet_walk();
		return 1'b1;
	endfunction

	// Packet building
	task automatic put_byte(logic [7:0] v);
		pkt.insert(pkt.size(), v);
	endtask

	task automatic put_cookie();
		for (int i = 0; i < 4; i++)
			put_byte(COOKIE[i]);
	endtask

	task automatic put_random(int n);
		repeat (n) put_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic add_sub(logic [7:0] code);
		relay_body.insert(relay_body.size(), code);
		relay_body.insert(relay_body.size(), (code == SUB_CIRCUIT) ? CIRCUIT_LEN : REMOTE_LEN);
		repeat ((code == SUB_CIRCUIT) ? 4 : REMOTE_ID_BYTES)
			relay_body.insert(relay_body.size(), 8'($urandom_range(0, 255)));
	endtask

	// Relay body: mostly a proper pair of sub-options, sometimes damaged
	task automatic put_relay(int len);
		int order;
		order = $urandom_range(0, 5);
		if (order < 3) begin
			add_sub(SUB_CIRCUIT);
			add_sub(SUB_REMOTE);
		end else if (order < 5) begin
			add_sub(SUB_REMOTE);
			add_sub(SUB_CIRCUIT);
		end else begin
			add_sub(SUB_CIRCUIT);
			add_sub(SUB_CIRCUIT);
		end
		while (relay_body.size() < RELAY_LEN)
			relay_body.insert(relay_body.size(), 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 4) == 0)
			relay_body[$urandom_range(0, relay_body.size() - 1)] = 8'($urandom_range(0, 255));
		for (int i = 0; i < len; i++)
			put_byte((i < relay_body.size()) ? relay_body[i] : 8'($urandom_range(0, 255)));
		relay_body.delete();
	endtask

	task automatic build_random_packet();
		int kind;
		int len;
		logic [7:0] code;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			put_random($urandom_range(1, 8));
			return;
		end
		if (kind == 1) begin
			put_cookie();
			pkt[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
			put_random($urandom_range(0, 8));
			return;
		end
		if (kind == 2) begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				put_byte(COOKIE[i]);
			return;
		end
		put_cookie();
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 3)) put_byte(OPT_PAD);
				1, 2: begin
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
					put_byte(OPT_MSG_TYPE);
					put_byte(8'(len));
					put_random(len);
				end
				3, 4: begin
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
					put_byte(OPT_REQ_ADDR);
					put_byte(8'(len));
					put_random(len);
				end
				5, 6, 7: begin
					len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : RELAY_LEN;
					put_byte(OPT_RELAY);
					put_byte(8'(len));
					put_relay(len);
				end
				default: begin
					code = 8'($urandom_range(1, 254));
					len = $urandom_range(0, 6);
					put_byte(code);
					put_byte(8'(len));
					put_random(len);
				end
			endcase
		end
		if ($urandom_range(0, 1) == 1) begin
			put_byte(OPT_END);
			put_random($urandom_range(0, 3));
		end
		// cut the region short at a random byte
		if ($urandom_range(0, 3) == 0) begin
			len = $urandom_range(1, pkt.size());
			while (pkt.size() > len)
				void'(pkt.pop_back());
		end
	endtask

	task automatic send_packet(bit drain);
		staged_t entry;
		for (int i = 0; i < pkt.size(); i++) begin
			entry.drain = drain && (i == 0);
			entry.req.option_byte = pkt[i];
			entry.req.last_byte = (i == pkt.size() - 1);
			byte_queue.insert(byte_queue.size(), entry);
		end
		staged_count += pkt.size();
		pkt.delete();
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_summary(opt_out_t want, opt_out_t got);
		check_field("region_ok", want.region_ok, got.region_ok);
		check_field("message_type", want.message_type, got.message_type);
		check_field("message_type_found", want.message_type_found, got.message_type_found);
		check_field("requested_address", want.requested_address, got.requested_address);
		check_field("requested_address_found", want.requested_address_found,
			got.requested_address_found);
		check_field("circuit_index", want.circuit_index, got.circuit_index);
		check_field("circuit_index_found", want.circuit_index_found, got.circuit_index_found);
		check_field("remote_ident", want.remote_ident, got.remote_ident);
		check_field("remote_ident_found", want.remote_ident_found, got.remote_ident_found);
		check_field("end_option_seen", want.end_option_seen, got.end_option_seen);
	endtask

	// Driver: offer requests in bursts, predict on each accepted request
	int gap_left;
	int burst_left;

	always @(posedge clk or negedge arst_n) begin : drive
		staged_t  nxt;
		opt_out_t summary;
		logic     show;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				if (parse_option_byte(byte_data, summary))
					expected_summaries.insert(expected_summaries.size(), summary);
			end
			// hold a stalled request, otherwise pick the next one
			if (!(byte_valid && byte_stall)) begin
				show = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (byte_queue.size() > 0 &&
						!(byte_queue[0].drain && expected_summaries.size() > 0)) begin
					nxt = byte_queue.pop_front();
					show = 1'b1;
					byte_data <= nxt.req;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
					end
				end
				byte_valid <= show;
			end
		end
	end

	// Monitor: check each taken summary, stall on a pattern of its own
	int stall_mode;
	int mode_left;
	int hold_left;
	int results_taken;
	bit long_hold_done;

	always @(posedge clk or negedge arst_n) begin : watch
		opt_out_t want;
		logic     hold_n;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_mode = 0;
			mode_left = 0;
			hold_left = 0;
			results_taken = 0;
			long_hold_done = 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_summaries.size() == 0) begin
					$error("result with no request pending");
					fail_count++;
				end else begin
					want = expected_summaries.pop_front();
					compare_summary(want, result);
				end
				results_taken++;
			end
			// hold off once for a long stretch so the input backs up
			if (results_taken >= 10 && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				hold_n = 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end else
					mode_left--;
				case (stall_mode)
					0: hold_n = 1'b0;
					1: hold_n = 1'($urandom_range(0, 1));
					default: hold_n = ($urandom_range(0, 7) != 0);
				endcase
			end
			result_stall <= hold_n;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int packets;
		fail_count = 0;
		cycle_count = 0;
		staged_count = 0;

		// Single stray byte, then every option kind with extreme values
		put_byte(8'hFF);
		send_packet(1'b0);
		put_cookie();
		put_byte(OPT_MSG_TYPE);
		put_byte(8'd1);
		put_byte(8'hFF);
		put_byte(OPT_REQ_ADDR);
		put_byte(8'd4);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h80);
		put_byte(8'h01);
		put_byte(OPT_RELAY);
		put_byte(RELAY_LEN);
		put_byte(SUB_CIRCUIT);
		put_byte(CIRCUIT_LEN);
		put_byte(8'hA5);
		put_byte(8'h5A);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(SUB_REMOTE);
		put_byte(REMOTE_LEN);
		for (int i = 0; i < REMOTE_ID_BYTES; i++)
			put_byte(8'h01 << i);
		put_byte(OPT_PAD);
		put_byte(OPT_END);
		send_packet(1'b0);

		// Random packets, now and then waiting for the pipeline to empty
		staged_count = 0;
		packets = 0;
		while (staged_count < 950 || packets < 50) begin
			build_random_packet();
			send_packet(packets % 12 == 0);
			packets++;
		end

		// Overlong region: one option ends inside the limit, the next crosses it
		put_cookie();
		while (pkt.size() < MAX_REGION_BYTES - 5)
			put_byte(OPT_PAD);
		put_byte(OPT_MSG_TYPE);
		put_byte(8'd1);
		put_byte(8'($urandom_range(0, 255)));
		put_byte(OPT_REQ_ADDR);
		put_byte(8'd4);
		put_random(12);
		send_packet(1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || byte_valid || expected_summaries.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_summaries.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
